// ----- rtl/q8sf_pkg.sv -----
package q8sf_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 17;
  // widest linear factor, e.g. csi + eta + 1 or 2*csi + eta
  localparam int FAC_W     = 18;
  // holds 1 - csi^2 scaled by 2^(2*FRAC_BITS)
  localparam int SQ_W      = 32;
  localparam int MUL_W     = SQ_W + FAC_W;
  localparam int CORNER_W  = 34;
  localparam int PROD_W    = CORNER_W + FAC_W;
  localparam int NODE_W    = 3;
  localparam int NODES     = 8;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam int K3 = 2 * FRAC_BITS + 2;
  localparam int K2 = 2 * FRAC_BITS + 1;
  localparam int D4 = FRAC_BITS + 2;
  localparam int D2 = FRAC_BITS + 1;
  localparam int D1 = FRAC_BITS;

  localparam logic signed [FAC_W-1:0] S_FAC   = FAC_W'(1) << FRAC_BITS;
  localparam logic signed [FAC_W-1:0] ONE_FAC = FAC_W'(1);
  localparam logic signed [SQ_W-1:0]  S_SQ    = SQ_W'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] csi;
    logic signed [COORD_W-1:0] eta;
    logic signed [SQ_W-1:0]    s2c;
    logic signed [SQ_W-1:0]    s2e;
  } coord_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    SH_K3,
    SH_K2,
    SH_D4,
    SH_D2,
    SH_D1
  } shift_e;

  // round half away from zero, then keep the low output bits
  function automatic logic [OUT_W-1:0] round_fix(input logic signed [PROD_W-1:0] x,
                                                 input shift_e sh);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    unique case (sh)
      SH_K3:   r = (mag + (PROD_W'(1) << (K3 - 1))) >> K3;
      SH_K2:   r = (mag + (PROD_W'(1) << (K2 - 1))) >> K2;
      SH_D4:   r = (mag + (PROD_W'(1) << (D4 - 1))) >> D4;
      SH_D2:   r = (mag + (PROD_W'(1) << (D2 - 1))) >> D2;
      SH_D1:   r = (mag + (PROD_W'(1) << (D1 - 1))) >> D1;
      default: r = '0;
    endcase
    r = x[PROD_W-1] ? -r : r;
    return r[OUT_W-1:0];
  endfunction

endpackage

// ----- rtl/q8sf_front.sv -----
module q8sf_front import q8sf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] csi_coord_i,
  input  logic signed [COORD_W-1:0] eta_coord_i,
  input  q_stat_t                   q_stat_i,
  output logic                      q_push_o,
  output coord_t                    q_data_o
);

  logic                      f_valid_q, f_valid_d;
  logic signed [COORD_W-1:0] f_csi_q, f_eta_q;
  logic signed [SQ_W-1:0]    csi_sq, eta_sq;
  logic                      accept;

  assign q_push_o   = f_valid_q && !q_stat_i.full;
  assign in_ready_o = !f_valid_q || !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (q_push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_csi_q <= csi_coord_i;
      f_eta_q <= eta_coord_i;
    end
  end

  // squared terms shared by the midside nodes
  assign csi_sq = SQ_W'(f_csi_q) * SQ_W'(f_csi_q);
  assign eta_sq = SQ_W'(f_eta_q) * SQ_W'(f_eta_q);

  always_comb begin
    q_data_o.csi = f_csi_q;
    q_data_o.eta = f_eta_q;
    q_data_o.s2c = S_SQ - csi_sq;
    q_data_o.s2e = S_SQ - eta_sq;
  end

endmodule

// ----- rtl/q8sf_fifo.sv -----
module q8sf_fifo import q8sf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  coord_t  push_data_i,
  input  logic    pop_i,
  output coord_t  head_o,
  output q_stat_t stat_o
);

  coord_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q, count_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (QPTR_W + 1)'(QDEPTH));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/q8sf_back.sv -----
module q8sf_back import q8sf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  coord_t                   q_head_i,
  input  q_stat_t                  q_stat_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic        [NODE_W-1:0] node_index_o,
  output logic signed [OUT_W-1:0]  shape_value_o,
  output logic signed [OUT_W-1:0]  deriv_csi_o,
  output logic signed [OUT_W-1:0]  deriv_eta_o,
  output logic                     last_node_o
);

  logic                    en, issue;
  logic [NODE_W-1:0]       node_q;

  logic signed [FAC_W-1:0] c18, e18;
  logic signed [FAC_W-1:0] cs_p, cs_m, sc_m, es_p, es_m, se_m;
  logic signed [FAC_W-1:0] c2pe, c2me, e2pc, e2mc;
  logic signed [FAC_W-1:0] ecs_pp, ecs_mp, ecs_pm, ecs_mm;

  logic signed [SQ_W-1:0]  va, da, ea;
  logic signed [FAC_W-1:0] vb, vd, db, eb;
  logic signed [MUL_W-1:0] vp, dp, ep;

  logic                    v1_q;
  logic [NODE_W-1:0]       node1_q;
  logic signed [MUL_W-1:0] vp1_q, dcp1_q, dep1_q;
  logic signed [FAC_W-1:0] vd1_q;

  logic                    v2_q;
  logic [NODE_W-1:0]       node2_q;
  logic signed [PROD_W-1:0] vp2_d, vp2_q;
  logic signed [MUL_W-1:0] dcp2_q, dep2_q;

  logic                    out_valid_q;
  logic [NODE_W-1:0]       node3_q;
  logic [OUT_W-1:0]        shape_q, dcsi_q, deta_q;
  shift_e                  sh_v, sh_c, sh_e;

  assign en      = !out_valid_q || out_ready_i;
  assign issue   = en && !q_stat_i.empty;
  assign q_pop_o = issue && (node_q == LAST_NODE);

  // linear factors of the current coordinate pair
  always_comb begin
    c18    = {{(FAC_W - COORD_W){q_head_i.csi[COORD_W-1]}}, q_head_i.csi};
    e18    = {{(FAC_W - COORD_W){q_head_i.eta[COORD_W-1]}}, q_head_i.eta};
    cs_p   = c18 + S_FAC;
    cs_m   = c18 - S_FAC;
    sc_m   = S_FAC - c18;
    es_p   = e18 + S_FAC;
    es_m   = e18 - S_FAC;
    se_m   = S_FAC - e18;
    c2pe   = (c18 <<< 1) + e18;
    c2me   = (c18 <<< 1) - e18;
    e2pc   = (e18 <<< 1) + c18;
    e2mc   = (e18 <<< 1) - c18;
    ecs_pp = e18 + c18 + S_FAC;
    ecs_mp = e18 - c18 + S_FAC;
    ecs_pm = e18 + c18 - S_FAC;
    ecs_mm = e18 - c18 - S_FAC;
  end

  // operand select per node
  always_comb begin
    va = SQ_W'(cs_m); vb = se_m; vd = ecs_pp;
    da = SQ_W'(se_m); db = c2pe;
    ea = SQ_W'(sc_m); eb = e2pc;
    unique case (node_q)
      3'd0: begin
        va = SQ_W'(cs_m); vb = se_m; vd = ecs_pp;
        da = SQ_W'(se_m); db = c2pe;
        ea = SQ_W'(sc_m); eb = e2pc;
      end
      3'd1: begin
        va = SQ_W'(cs_p); vb = es_m; vd = ecs_mp;
        da = SQ_W'(se_m); db = c2me;
        ea = SQ_W'(cs_p); eb = e2mc;
      end
      3'd2: begin
        va = SQ_W'(cs_p); vb = es_p; vd = ecs_pm;
        da = SQ_W'(es_p); db = c2pe;
        ea = SQ_W'(cs_p); eb = e2pc;
      end
      3'd3: begin
        va = SQ_W'(sc_m); vb = es_p; vd = ecs_mm;
        da = SQ_W'(es_p); db = c2me;
        ea = SQ_W'(sc_m); eb = e2mc;
      end
      3'd4: begin
        va = q_head_i.s2c; vb = se_m; vd = ONE_FAC;
        da = SQ_W'(c18); db = es_m;
        ea = -q_head_i.s2c; eb = ONE_FAC;
      end
      3'd5: begin
        va = q_head_i.s2e; vb = cs_p; vd = ONE_FAC;
        da = q_head_i.s2e; db = ONE_FAC;
        ea = -SQ_W'(cs_p); eb = e18;
      end
      3'd6: begin
        va = q_head_i.s2c; vb = es_p; vd = ONE_FAC;
        da = -SQ_W'(c18); db = es_p;
        ea = q_head_i.s2c; eb = ONE_FAC;
      end
      3'd7: begin
        va = q_head_i.s2e; vb = sc_m; vd = ONE_FAC;
        da = -q_head_i.s2e; db = ONE_FAC;
        ea = SQ_W'(cs_m); eb = e18;
      end
      default: ;
    endcase
  end

  assign vp = MUL_W'(va) * MUL_W'(vb);
  assign dp = MUL_W'(da) * MUL_W'(db);
  assign ep = MUL_W'(ea) * MUL_W'(eb);

  // corner values take a third factor, midside values pass through
  always_comb begin
    if (!node1_q[NODE_W-1]) begin
      vp2_d = PROD_W'($signed(vp1_q[CORNER_W-1:0])) * PROD_W'(vd1_q);
    end else begin
      vp2_d = PROD_W'(vp1_q);
    end
  end

  always_comb begin
    sh_v = node2_q[NODE_W-1] ? SH_K2 : SH_K3;
    sh_c = SH_D4;
    sh_e = SH_D4;
    if (node2_q[NODE_W-1]) begin
      sh_c = node2_q[0] ? SH_D2 : SH_D1;
      sh_e = node2_q[0] ? SH_D1 : SH_D2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        node_q <= node_q + 1'b1;
      end
      if (en) begin
        v1_q        <= issue;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      node1_q <= node_q;
      vp1_q   <= vp;
      vd1_q   <= vd;
      dcp1_q  <= dp;
      dep1_q  <= ep;
      node2_q <= node1_q;
      vp2_q   <= vp2_d;
      dcp2_q  <= dcp1_q;
      dep2_q  <= dep1_q;
      node3_q <= node2_q;
      shape_q <= round_fix(vp2_q, sh_v);
      dcsi_q  <= round_fix(PROD_W'(dcp2_q), sh_c);
      deta_q  <= round_fix(PROD_W'(dep2_q), sh_e);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign node_index_o  = node3_q;
  assign shape_value_o = shape_q;
  assign deriv_csi_o   = dcsi_q;
  assign deriv_eta_o   = deta_q;
  assign last_node_o   = (node3_q == LAST_NODE);

endmodule

// ----- rtl/quad8_shape_function_eval_core.sv -----
// Evaluates the eight shape functions of the 8-node serendipity quadrilateral and their
// csi and eta derivatives at one natural point (csi, eta), 14 fractional bits. Every
// accepted pair gives eight results, node 0 first, with last_node_o set on node 7; each
// value is rounded to nearest with ties away from zero and wraps to 17 bits. The back end
// issues one node per cycle, when the output is not stalled, into a shared multiply,
// multiply, round pipeline, and pops a pair from the queue when it issues node 7. The
// front end registers the pair and forms 1 - csi^2 and 1 - eta^2, then hands it to a
// two-entry queue.
module quad8_shape_function_eval_core import q8sf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] csi_coord_i,
  input  logic signed [COORD_W-1:0] eta_coord_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic        [NODE_W-1:0]  node_index_o,
  output logic signed [OUT_W-1:0]   shape_value_o,
  output logic signed [OUT_W-1:0]   deriv_csi_o,
  output logic signed [OUT_W-1:0]   deriv_eta_o,
  output logic                      last_node_o
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  coord_t  q_wdata, q_head;

  q8sf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .csi_coord_i (csi_coord_i),
    .eta_coord_i (eta_coord_i),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  q8sf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  q8sf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_head_i      (q_head),
    .q_stat_i      (q_stat),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .node_index_o  (node_index_o),
    .shape_value_o (shape_value_o),
    .deriv_csi_o   (deriv_csi_o),
    .deriv_eta_o   (deriv_eta_o),
    .last_node_o   (last_node_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("request popped from an empty queue");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_stat.full)
    else $error("input stalled while the queue has room");

endmodule
